@@ rtl/core/dchf_pkg.sv @@
// Package for the depth column hole filler.
// Holds widths, limits and the command and status types shared by the controller and datapath.
// No dependencies.
package dchf_pkg;

    localparam int DEPTH_W = 16;
    localparam int CNT_W   = 7;
    localparam int BIT_W   = 4;
    localparam logic [CNT_W-1:0] MAX_GAP   = 7'd64;
    localparam logic [CNT_W-1:0] GAP_RESET = 7'd64;

    typedef struct packed {
        logic load;
        logic step;
        logic put_zero;
        logic put_fill;
        logic put_last;
    } t_dchf_cmd;

    typedef struct packed {
        logic zero;
        logic have_above;
        logic pending_nz;
        logic release_run;
        logic cnt_one;
        logic div_last;
        logic out_free;
    } t_dchf_status;

endpackage

@@ rtl/core/depth_column_hole_fill_top.sv @@
// Depth column hole filler: fills short vertical zero runs between two nonzero samples of a
// column by stepwise interpolation. A sample that needs no filling passes through the S_LAST
// state into the output register. Each filled sample runs through a serial divider, which
// produces one quotient bit per cycle, then S_FILL passes it to the output register.
// Held zeros released unfilled leave at one per cycle while the output register is free.
// The next sample is taken once all results of the current one sit in or have passed the
// output register.
// Depends on dchf_pkg, dchf_ctrl and dchf_dpath.
module depth_column_hole_fill_top
    import dchf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [DEPTH_W-1:0] i_depth,
    input  logic               i_column_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [DEPTH_W-1:0] o_depth_out,
    output logic               o_filled,
    output logic               o_column_end_out
);

    t_dchf_cmd    cmd;
    t_dchf_status status;

    dchf_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_column_end (i_column_end),
        .i_status     (status),
        .o_ready      (o_ready),
        .o_cmd        (cmd)
    );

    dchf_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_depth          (i_depth),
        .i_column_end     (i_column_end),
        .i_cmd            (cmd),
        .i_ready          (i_ready),
        .o_status         (status),
        .o_valid          (o_valid),
        .o_depth_out      (o_depth_out),
        .o_filled         (o_filled),
        .o_column_end_out (o_column_end_out)
    );

endmodule

@@ rtl/core/dchf_ctrl.sv @@
// Controller of the depth column hole filler: sequences the transfers of one input item.
// Depends on dchf_pkg.
module dchf_ctrl
    import dchf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic         i_column_end,
    input  t_dchf_status i_status,
    output logic         o_ready,
    output t_dchf_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ZERO = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_FILL = 3'd3;
    localparam logic [2:0] S_LAST = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_tail;
    logic       n_tail;
    logic       accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state = r_state;
        n_tail  = r_tail;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    if (i_status.zero) begin
                        if (i_column_end) begin
                            n_tail  = 1'b1;
                            n_state = i_status.pending_nz ? S_ZERO : S_LAST;
                        end else if (!i_status.have_above) begin
                            n_state = S_LAST;
                        end else if (i_status.release_run) begin
                            n_tail  = 1'b0;
                            n_state = S_ZERO;
                        end
                    end else begin
                        n_state = i_status.pending_nz ? S_DIV : S_LAST;
                    end
                end
            end
            S_ZERO: begin
                if (i_status.out_free) begin
                    o_cmd.put_zero = 1'b1;
                    if (i_status.cnt_one) begin
                        n_state = r_tail ? S_LAST : S_IDLE;
                    end
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (i_status.out_free) begin
                    o_cmd.put_fill = 1'b1;
                    n_state = i_status.cnt_one ? S_LAST : S_DIV;
                end
            end
            S_LAST: begin
                if (i_status.out_free) begin
                    o_cmd.put_last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tail  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tail  <= n_tail;
        end
    end

endmodule

@@ rtl/core/dchf_dpath.sv @@
// Datapath of the depth column hole filler: column state, run counter, serial divider
// and output register. Depends on dchf_pkg.
module dchf_dpath
    import dchf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CNT_W-1:0]   i_cfg_data,
    input  logic [DEPTH_W-1:0] i_depth,
    input  logic               i_column_end,
    input  t_dchf_cmd          i_cmd,
    input  logic               i_ready,
    output t_dchf_status       o_status,
    output logic               o_valid,
    output logic [DEPTH_W-1:0] o_depth_out,
    output logic               o_filled,
    output logic               o_column_end_out
);

    logic [CNT_W-1:0]   r_gap_limit;
    logic [DEPTH_W-1:0] r_last_valid;
    logic               r_have_above;
    logic [CNT_W-1:0]   r_pending;

    logic [DEPTH_W-1:0] r_in_depth;
    logic               r_in_cend;
    logic [DEPTH_W-1:0] r_prev;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   r_den;

    logic [CNT_W-1:0]   r_rem;
    logic [DEPTH_W-1:0] r_quo;
    logic               r_neg;
    logic [BIT_W-1:0]   r_bit;

    logic               r_out_valid;
    logic [DEPTH_W-1:0] r_out_depth;
    logic               r_out_filled;
    logic               r_out_cend;

    logic [CNT_W-1:0]   lim;
    logic [CNT_W-1:0]   pend_inc;
    logic               in_zero;
    logic               out_free;
    logic [DEPTH_W-1:0] init_prev;
    logic [DEPTH_W-1:0] init_end;
    logic [DEPTH_W:0]   diff;
    logic [DEPTH_W:0]   diff_mag;
    logic [CNT_W:0]     shifted;
    logic               sub_ok;
    logic [DEPTH_W:0]   adj;
    logic [DEPTH_W:0]   fill_sum;
    logic [DEPTH_W-1:0] fill_val;

    always_comb begin
        if (r_gap_limit == '0) begin
            lim = CNT_W'(1);
        end else if (r_gap_limit > MAX_GAP) begin
            lim = MAX_GAP;
        end else begin
            lim = r_gap_limit;
        end
    end

    assign pend_inc = r_pending + CNT_W'(1);
    assign in_zero  = (i_depth == '0);
    assign out_free = !r_out_valid || i_ready;

    assign o_status.zero        = in_zero;
    assign o_status.have_above  = r_have_above;
    assign o_status.pending_nz  = (r_pending != '0);
    assign o_status.release_run = (pend_inc >= lim);
    assign o_status.cnt_one     = (r_cnt == CNT_W'(1));
    assign o_status.div_last    = (r_bit == {BIT_W{1'b1}});
    assign o_status.out_free    = out_free;

    // Serial restoring division of |end - prev| by the row distance.
    assign shifted = {r_rem, r_quo[DEPTH_W-1]};
    assign sub_ok  = (shifted >= {1'b0, r_den});

    // Floor division: a negative difference rounds the magnitude quotient up.
    assign adj      = {1'b0, r_quo} + {{DEPTH_W{1'b0}}, (r_rem != '0)};
    assign fill_sum = r_neg ? ({1'b0, r_prev} - adj) : ({1'b0, r_prev} + {1'b0, r_quo});
    assign fill_val = fill_sum[DEPTH_W-1:0];

    assign init_prev = i_cmd.load ? r_last_valid : fill_val;
    assign init_end  = i_cmd.load ? i_depth : r_in_depth;
    assign diff      = {1'b0, init_end} - {1'b0, init_prev};
    assign diff_mag  = diff[DEPTH_W] ? (~diff + (DEPTH_W+1)'(1)) : diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_limit  <= GAP_RESET;
            r_last_valid <= '0;
            r_have_above <= 1'b0;
            r_pending    <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_gap_limit <= i_cfg_data;
            end
            if (i_cmd.load) begin
                if (in_zero) begin
                    if (i_column_end) begin
                        r_pending    <= '0;
                        r_have_above <= 1'b0;
                    end else if (r_have_above) begin
                        if (pend_inc >= lim) begin
                            r_pending    <= '0;
                            r_have_above <= 1'b0;
                        end else begin
                            r_pending <= pend_inc;
                        end
                    end
                end else begin
                    r_pending    <= '0;
                    r_last_valid <= i_depth;
                    r_have_above <= !i_column_end;
                end
            end
            if (i_cmd.put_zero || i_cmd.put_fill || i_cmd.put_last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_depth <= i_depth;
            r_in_cend  <= i_column_end;
            r_prev     <= r_last_valid;
            r_cnt      <= (in_zero && !i_column_end && r_have_above) ? pend_inc : r_pending;
            r_den      <= pend_inc;
        end
        if (i_cmd.load || i_cmd.put_fill) begin
            r_rem <= '0;
            r_quo <= diff_mag[DEPTH_W-1:0];
            r_neg <= diff[DEPTH_W];
            r_bit <= '0;
        end else if (i_cmd.step) begin
            r_rem <= sub_ok ? CNT_W'(shifted - {1'b0, r_den}) : shifted[CNT_W-1:0];
            r_quo <= {r_quo[DEPTH_W-2:0], sub_ok};
            r_bit <= r_bit + BIT_W'(1);
        end
        if (i_cmd.put_zero) begin
            r_cnt        <= r_cnt - CNT_W'(1);
            r_out_depth  <= '0;
            r_out_filled <= 1'b0;
            r_out_cend   <= 1'b0;
        end
        if (i_cmd.put_fill) begin
            r_cnt        <= r_cnt - CNT_W'(1);
            r_den        <= r_cnt;
            r_prev       <= fill_val;
            r_out_depth  <= fill_val;
            r_out_filled <= 1'b1;
            r_out_cend   <= 1'b0;
        end
        if (i_cmd.put_last) begin
            r_out_depth  <= r_in_depth;
            r_out_filled <= 1'b0;
            r_out_cend   <= r_in_cend;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_depth_out      = r_out_depth;
    assign o_filled         = r_out_filled;
    assign o_column_end_out = r_out_cend;

`ifndef ASSERT_OFF
    a_pending_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending != '0) |-> r_have_above)
        else $error("Held zeros without a valid sample above.");

    a_fill_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put_fill |-> (r_cnt != '0) && (r_den >= CNT_W'(2)))
        else $error("Fill issued with an invalid row distance.");

    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_filled) |-> (r_out_depth != '0))
        else $error("Interpolated sample is zero.");
`endif

endmodule
